### src/two_color_csr_builder_top_defines.svh
// Assertion macros for the two-color CSR builder checker.
`ifndef TWO_COLOR_CSR_BUILDER_TOP_DEFINES_SVH
`define TWO_COLOR_CSR_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSRB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csrb check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSRB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csrb check failed");

`endif

### src/csrb_pkg.sv
// Types, constants and codes shared by the two-color CSR builder.
package csrb_pkg;

    localparam int VERTEX_COUNT  = 1024;
    localparam int EDGE_CAPACITY = 65536;

    localparam int VTX_W   = 10;
    localparam int COLOR_W = 2;
    localparam int POS_W   = 16;
    localparam int RANGE_W = 17;

    localparam int VIDX_W    = $clog2(VERTEX_COUNT);
    localparam int ADDR_W    = VIDX_W + 1;
    localparam int MEM_DEPTH = 2 * VERTEX_COUNT;
    localparam int CNT_W     = $clog2(EDGE_CAPACITY + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [COLOR_W-1:0] COLOR_ONE = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_TWO = 2'd2;

    typedef enum logic [1:0] {
        ACT_COUNT  = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_PLACE  = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_EXEC,
        ST_FRD,
        ST_FWR
    } back_state_t;

    typedef struct packed {
        action_t             action;
        logic [VTX_W-1:0]    source_vertex;
        logic [VTX_W-1:0]    target_vertex;
        logic [COLOR_W-1:0]  edge_color;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  out_color;
        logic [POS_W-1:0]    slot_position;
        logic [VTX_W-1:0]    slot_target;
        logic [RANGE_W-1:0]  range_start;
        logic [RANGE_W-1:0]  range_end;
        logic [RANGE_W-1:0]  color_total;
        logic                overflow;
    } result_t;

    typedef struct packed {
        action_t             kind;
        logic                color_idx;
        logic [VIDX_W-1:0]   vertex;
        logic [VTX_W-1:0]    target;
        logic                placing;
    } op_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

endpackage

### src/csrb_front.sv
// Front end: accepts items, drops the ones with no effect, queues the rest.
module csrb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  csrb_pkg::item_t    item,
    output csrb_pkg::op_t      head,
    output logic               head_valid,
    input  csrb_pkg::back_ctrl_t back
);

    csrb_pkg::op_t              q_reg [csrb_pkg::QDEPTH];
    logic [csrb_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csrb_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [csrb_pkg::QPTR_W:0]   fill_reg, fill_next;
    logic                        placing_reg, placing_next;

    logic          accept;
    logic          good;
    logic          keep;
    logic          push;
    logic          pop;
    csrb_pkg::op_t entry;

    assign item_stall = (fill_reg == (csrb_pkg::QPTR_W + 1)'(csrb_pkg::QDEPTH)) | back.clearing;
    assign accept     = item_valid & ~item_stall;
    assign pop        = back.pop;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (fill_reg != '0);

    assign good = ((item.edge_color == csrb_pkg::COLOR_ONE) ||
                   (item.edge_color == csrb_pkg::COLOR_TWO)) &&
                  (32'(item.source_vertex) < 32'(csrb_pkg::VERTEX_COUNT));

    always_comb
    begin
        unique case (item.action)
            csrb_pkg::ACT_COUNT:  keep = good & ~placing_reg;
            csrb_pkg::ACT_FINISH: keep = ~placing_reg;
            csrb_pkg::ACT_PLACE:  keep = good & placing_reg;
            csrb_pkg::ACT_QUERY:  keep = good;
            default:              keep = 1'b0;
        endcase
    end

    assign push = accept & keep;

    always_comb
    begin
        entry.kind      = item.action;
        entry.color_idx = (item.edge_color == csrb_pkg::COLOR_TWO);
        entry.vertex    = csrb_pkg::VIDX_W'(item.source_vertex);
        entry.target    = item.target_vertex;
        entry.placing   = placing_reg;
    end

    always_comb
    begin
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next    = fill_reg + (csrb_pkg::QPTR_W + 1)'(push)
                                - (csrb_pkg::QPTR_W + 1)'(pop);
        placing_next = placing_reg | (push && item.action == csrb_pkg::ACT_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            placing_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            placing_reg <= placing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

### src/csrb_back.sv
// Back end: degree and cursor memories, prefix walk, result register.
module csrb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csrb_pkg::op_t         head,
    input  logic                  head_valid,
    output csrb_pkg::back_ctrl_t  ctrl,
    output logic                  result_valid,
    input  logic                  result_stall,
    output csrb_pkg::result_t     result
);

    localparam logic [csrb_pkg::CNT_W-1:0] CAP = csrb_pkg::CNT_W'(csrb_pkg::EDGE_CAPACITY);
    localparam logic [csrb_pkg::ADDR_W-1:0] LAST = csrb_pkg::ADDR_W'(csrb_pkg::MEM_DEPTH - 1);

    logic [csrb_pkg::CNT_W-1:0] deg_mem [csrb_pkg::MEM_DEPTH];
    logic [csrb_pkg::CNT_W-1:0] cur_mem [csrb_pkg::MEM_DEPTH];

    csrb_pkg::back_state_t       state_reg, state_next;
    csrb_pkg::op_t               op_reg, op_next;
    logic [csrb_pkg::ADDR_W-1:0] walk_reg, walk_next;
    logic [csrb_pkg::CNT_W-1:0]  sum_reg, sum_next;
    logic [csrb_pkg::CNT_W-1:0]  cnt_reg [2];
    logic [csrb_pkg::CNT_W-1:0]  cnt_next [2];
    logic                        ovf_reg, ovf_next;
    logic [csrb_pkg::CNT_W-1:0]  start_reg, start_next;
    logic                        res_valid_reg, res_valid_next;
    csrb_pkg::result_t           res_reg, res_next;
    logic [csrb_pkg::CNT_W-1:0]  deg_q_reg, cur_q_reg;

    logic                        deg_re, cur_re, deg_we, cur_we;
    logic [csrb_pkg::ADDR_W-1:0] deg_ra, cur_ra, deg_wa, cur_wa;
    logic [csrb_pkg::CNT_W-1:0]  deg_wd, cur_wd;

    logic [csrb_pkg::ADDR_W-1:0] op_idx, head_idx;
    logic                        out_free;
    logic [csrb_pkg::CNT_W-1:0]  walk_sum;
    logic                        walk_sat;
    logic [csrb_pkg::COLOR_W-1:0] op_color;

    assign op_idx   = {op_reg.color_idx, op_reg.vertex};
    assign head_idx = {head.color_idx, head.vertex};
    assign out_free = ~res_valid_reg | ~result_stall;
    assign op_color = op_reg.color_idx ? csrb_pkg::COLOR_TWO : csrb_pkg::COLOR_ONE;
    assign walk_sat = deg_q_reg > (CAP - sum_reg);
    assign walk_sum = walk_sat ? CAP : sum_reg + deg_q_reg;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        walk_next      = walk_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        start_next     = start_reg;
        res_valid_next = res_valid_reg & result_stall;
        res_next       = res_reg;
        deg_re         = 1'b0;
        cur_re         = 1'b0;
        deg_we         = 1'b0;
        cur_we         = 1'b0;
        deg_ra         = op_idx;
        cur_ra         = op_idx;
        deg_wa         = op_idx;
        cur_wa         = op_idx;
        deg_wd         = '0;
        cur_wd         = '0;
        ctrl.pop       = 1'b0;
        ctrl.clearing  = 1'b0;

        unique case (state_reg)
            csrb_pkg::ST_CLEAR:
            begin
                ctrl.clearing = 1'b1;
                deg_we        = 1'b1;
                deg_wa        = walk_reg;
                deg_wd        = '0;
                walk_next     = walk_reg + 1'b1;
                if (walk_reg == LAST)
                begin
                    walk_next  = '0;
                    state_next = csrb_pkg::ST_IDLE;
                end
            end

            csrb_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    ctrl.pop = 1'b1;
                    op_next  = head;
                    unique case (head.kind)
                        csrb_pkg::ACT_FINISH:
                        begin
                            walk_next  = '0;
                            sum_next   = '0;
                            state_next = csrb_pkg::ST_FRD;
                        end
                        csrb_pkg::ACT_QUERY:
                        begin
                            deg_re     = 1'b1;
                            deg_ra     = head_idx - 1'b1;
                            state_next = csrb_pkg::ST_QRD;
                        end
                        default:
                        begin
                            deg_re     = 1'b1;
                            cur_re     = 1'b1;
                            deg_ra     = head_idx;
                            cur_ra     = head_idx;
                            state_next = csrb_pkg::ST_EXEC;
                        end
                    endcase
                end
            end

            csrb_pkg::ST_QRD:
            begin
                start_next = (op_reg.placing && op_reg.vertex != '0) ? deg_q_reg : '0;
                deg_re     = 1'b1;
                deg_ra     = op_idx;
                state_next = csrb_pkg::ST_EXEC;
            end

            csrb_pkg::ST_EXEC:
            begin
                unique case (op_reg.kind)
                    csrb_pkg::ACT_COUNT:
                    begin
                        if (cnt_reg[op_reg.color_idx] >= CAP)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next[op_reg.color_idx] = cnt_reg[op_reg.color_idx] + 1'b1;
                            deg_we = 1'b1;
                            deg_wd = deg_q_reg + 1'b1;
                        end
                        state_next = csrb_pkg::ST_IDLE;
                    end
                    csrb_pkg::ACT_PLACE:
                    begin
                        if (out_free)
                        begin
                            if (cur_q_reg < deg_q_reg)
                            begin
                                cur_we = 1'b1;
                                cur_wd = cur_q_reg + 1'b1;
                            end
                            res_next.out_color     = op_color;
                            res_next.slot_position = csrb_pkg::POS_W'(cur_q_reg);
                            res_next.slot_target   = op_reg.target;
                            res_next.range_start   = '0;
                            res_next.range_end     = '0;
                            res_next.color_total   = '0;
                            res_next.overflow      = ovf_reg | ~(cur_q_reg < deg_q_reg);
                            ovf_next               = ovf_reg | ~(cur_q_reg < deg_q_reg);
                            res_valid_next         = 1'b1;
                            state_next             = csrb_pkg::ST_IDLE;
                        end
                    end
                    csrb_pkg::ACT_QUERY:
                    begin
                        if (out_free)
                        begin
                            res_next.out_color     = op_color;
                            res_next.slot_position = '0;
                            res_next.slot_target   = '0;
                            res_next.range_start   = csrb_pkg::RANGE_W'(start_reg);
                            res_next.range_end     = csrb_pkg::RANGE_W'(deg_q_reg);
                            res_next.color_total   =
                                csrb_pkg::RANGE_W'(cnt_reg[op_reg.color_idx]);
                            res_next.overflow      = ovf_reg;
                            res_valid_next         = 1'b1;
                            state_next             = csrb_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = csrb_pkg::ST_IDLE;
                    end
                endcase
            end

            csrb_pkg::ST_FRD:
            begin
                deg_re     = 1'b1;
                deg_ra     = walk_reg;
                state_next = csrb_pkg::ST_FWR;
            end

            csrb_pkg::ST_FWR:
            begin
                cur_we   = 1'b1;
                cur_wa   = walk_reg;
                cur_wd   = sum_reg;
                deg_we   = 1'b1;
                deg_wa   = walk_reg;
                deg_wd   = walk_sum;
                ovf_next = ovf_reg | walk_sat;
                // each color's sum starts over at its first vertex
                sum_next = (&walk_reg[csrb_pkg::VIDX_W-1:0]) ? '0 : walk_sum;
                if (walk_reg == LAST)
                begin
                    walk_next  = '0;
                    state_next = csrb_pkg::ST_IDLE;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = csrb_pkg::ST_FRD;
                end
            end

            default:
            begin
                state_next = csrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csrb_pkg::ST_CLEAR;
            walk_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        start_reg <= start_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_wa] <= deg_wd;
        end
        if (deg_re)
        begin
            deg_q_reg <= deg_mem[deg_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_wa] <= cur_wd;
        end
        if (cur_re)
        begin
            cur_q_reg <= cur_mem[cur_ra];
        end
    end

endmodule

### src/two_color_csr_builder_top.sv
// Top level of the two-color CSR builder.
// After reset the block clears all 2*VERTEX_COUNT = 2048 entries of its
// degree memory, one entry a cycle, holding item_stall high. A four-word queue
// then lets items in while earlier ones execute. The back end runs one item
// at a time against single-port degree and cursor memories with registered
// reads: count and place items read their entries and then execute, queries
// make two reads of the degree memory before they execute, and finish walks
// every color and vertex, reading each degree entry and then writing its
// cursor and running sum. Items with a bad color or vertex, or in the wrong
// phase, are dropped at the front in the cycle they are taken. A place or
// query result sits in an output register while the next word is accepted.
module two_color_csr_builder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  csrb_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output csrb_pkg::result_t   result
);

    csrb_pkg::op_t        head;
    logic                 head_valid;
    csrb_pkg::back_ctrl_t back_ctrl;

    csrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .back       (back_ctrl)
    );

    csrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .ctrl         (back_ctrl),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### src/two_color_csr_builder_chk.sv
// Port-level checker for the two-color CSR builder, bound to the top level.
`include "two_color_csr_builder_top_defines.svh"

module two_color_csr_builder_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input csrb_pkg::result_t result
);

    `CSRB_ASSERT_NXT(a_res_hold, result_valid && result_stall, result_valid)
    `CSRB_ASSERT_NXT(a_res_stable, result_valid && result_stall, $stable(result))
    `CSRB_ASSERT_IMP(a_res_color, result_valid, result.out_color == csrb_pkg::COLOR_ONE || result.out_color == csrb_pkg::COLOR_TWO)
    `CSRB_ASSERT_IMP(a_res_kind, result_valid, (result.slot_position == '0 && result.slot_target == '0) || (result.range_start == '0 && result.range_end == '0 && result.color_total == '0))
    `CSRB_ASSERT_IMP(a_res_range, result_valid, result.range_start <= result.range_end)

endmodule

bind two_color_csr_builder_top two_color_csr_builder_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
